// ===== rtl/binary_min_heap_queue_top_defines.svh =====
// Assertion macros for the binary min-heap queue.
// Included by the top level; no other dependencies.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BMHQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmhq assertion failed");
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmhq assertion failed");
`else
`define BMHQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed
    {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/binary_min_heap_queue_top.sv =====
// Top level of the min-priority queue: a row of sorted cells plus count and result logic.
// Depends on bmhq_pkg, bmhq_cell and binary_min_heap_queue_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_queue_top_defines.svh"

// Usage
//   Command channel: drive command and value with start high; the transaction is
//   taken at a rising edge where start is high and busy is low.
//   command 0 inserts value, command 1 removes the minimum.
//   Result channel: done is high for exactly one cycle, in the cycle after the
//   command is taken, with status, top_value, count and is_empty.
//   The receiver cannot stall; results are not held beyond that cycle.
// Timing
//   Each command updates the whole row at once: all HEAP_DEPTH cells compare the
//   broadcast value against their element and shift by one place in parallel.
//   busy is high during the result cycle, so a new command is not taken while
//   done is high.
// Reset
//   rst_n clears the element count and the result strobe; cell contents are
//   not cleared and are only read below the count.
// Status: 0 ok, 1 insert refused because full, 2 remove on empty ignored.

module binary_min_heap_queue_top
#(
    parameter int HEAP_DEPTH = 256
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 command,
    input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  value,
    output logic                                      done,
    output logic [bmhq_pkg::STATUS_W-1:0]             status,
    output logic signed [bmhq_pkg::VALUE_W-1:0]       top_value,
    output logic [bmhq_pkg::COUNT_W-1:0]              count,
    output logic                                      is_empty
);

    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

    logic                  accept;
    logic                  is_full;
    logic                  cnt_zero;
    bmhq_pkg::cell_ctl_t   ctl;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    bmhq_pkg::status_t     status_reg;
    bmhq_pkg::status_t     status_next;

    logic signed [bmhq_pkg::VALUE_W-1:0] cell_data [HEAP_DEPTH];
    logic                                cell_place [HEAP_DEPTH];
    logic                                cell_occ [HEAP_DEPTH];

    assign busy     = done_reg;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(HEAP_DEPTH));
    assign cnt_zero = (count_reg == '0);

    always_comb
    begin
        ctl.value   = value;
        ctl.ins     = 1'b0;
        ctl.rem     = 1'b0;
        count_next  = count_reg;
        status_next = bmhq_pkg::ST_OK;
        if (accept)
        begin
            if (command == bmhq_pkg::CMD_INSERT)
            begin
                if (is_full)
                begin
                    status_next = bmhq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (cnt_zero)
                begin
                    status_next = bmhq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctl.rem    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < HEAP_DEPTH; gi++)
        begin : g_cell
            logic signed [bmhq_pkg::VALUE_W-1:0] prev_d;
            logic                                prev_p;
            logic signed [bmhq_pkg::VALUE_W-1:0] next_d;

            assign cell_occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign prev_d = value;
                assign prev_p = 1'b0;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
                assign prev_p = cell_place[gi-1];
            end

            if (gi == HEAP_DEPTH - 1)
            begin : g_last
                // nothing beyond the end; hold the stale element
                assign next_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign next_d = cell_data[gi+1];
            end

            bmhq_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (cell_occ[gi]),
                .prev_data  (prev_d),
                .prev_place (prev_p),
                .next_data  (next_d),
                .data       (cell_data[gi]),
                .place      (cell_place[gi])
            );
        end
    endgenerate

    assign done      = done_reg;
    assign status    = status_reg;
    assign top_value = cnt_zero ? '0 : cell_data[0];
    assign count     = bmhq_pkg::COUNT_W'(count_reg);
    assign is_empty  = cnt_zero;

    `BMHQ_ASSERT_NEXT(a_accept_done, clk, rst_n, accept, done_reg)
    `BMHQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(HEAP_DEPTH))
    `BMHQ_ASSERT_SAME(a_full_status, clk, rst_n,
        done_reg && (status_reg == bmhq_pkg::ST_FULL), is_full)
    `BMHQ_ASSERT_SAME(a_row_sorted, clk, rst_n,
        done_reg && cell_occ[1], cell_data[0] <= cell_data[1])

endmodule

`default_nettype wire

// ===== rtl/bmhq_cell.sv =====
// One cell of the sorted row: holds one element and trades it with its neighbors.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cell
(
    input  wire logic                               clk,
    input  wire bmhq_pkg::cell_ctl_t                ctl,
    input  wire logic                               occupied,
    input  wire logic signed [bmhq_pkg::VALUE_W-1:0] prev_data,
    input  wire logic                               prev_place,
    input  wire logic signed [bmhq_pkg::VALUE_W-1:0] next_data,
    output logic signed [bmhq_pkg::VALUE_W-1:0]      data,
    output logic                                    place
);

    logic signed [bmhq_pkg::VALUE_W-1:0] data_reg;
    logic signed [bmhq_pkg::VALUE_W-1:0] data_next;

    // New value lands here or earlier: row stays ascending.
    assign place = !occupied || (ctl.value < data_reg);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (place)
            begin
                // first placing cell takes the new value, later ones shift up
                data_next = prev_place ? prev_data : ctl.value;
            end
        end
        else if (ctl.rem)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== tb/binary_min_heap_queue_top_tb.sv =====
// Self-checking testbench for binary_min_heap_queue_top: a heap tracker predicts each result.
// Depends on bmhq_pkg and the binary_min_heap_queue_top RTL.
`timescale 1ns / 1ps

module binary_min_heap_queue_top_tb;

    localparam int DEPTH       = 256;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int IDLE_PCT    = 23;
    localparam int RANDOM_ITEMS = 1430;

    typedef struct
    {
        bmhq_pkg::status_t                   st;
        logic signed [bmhq_pkg::VALUE_W-1:0] top;
        logic [bmhq_pkg::COUNT_W-1:0]        cnt;
        logic                                empty;
    } heap_result_t;

    // Tracks the heap contents and queues the result each command should produce.
    class min_heap_tracker;
        logic signed [bmhq_pkg::VALUE_W-1:0] heap_slots[DEPTH];
        int                                  held;
        heap_result_t                        pending_results[$];
        int                                  faults;

        function new();
            held   = 0;
            faults = 0;
        endfunction

        function void push_value(logic signed [bmhq_pkg::VALUE_W-1:0] v);
            int pos;
            int up;
            pos = held;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (!(v < heap_slots[up]))
                    break;
                heap_slots[pos] = heap_slots[up];
                pos = up;
            end
            heap_slots[pos] = v;
            held++;
        endfunction

        function void pop_min();
            int                                  n;
            int                                  pos;
            int                                  lc;
            int                                  rc;
            int                                  best;
            logic signed [bmhq_pkg::VALUE_W-1:0] t;
            n = held - 1;
            pos = 0;
            heap_slots[0] = heap_slots[n];
            held = n;
            forever begin
                lc = 2 * pos + 1;
                rc = lc + 1;
                best = pos;
                if (lc >= n)
                    break;
                if (heap_slots[lc] < heap_slots[best])
                    best = lc;
                if (rc < n && heap_slots[rc] < heap_slots[best])
                    best = rc;
                if (best == pos)
                    break;
                t = heap_slots[best];
                heap_slots[best] = heap_slots[pos];
                heap_slots[pos] = t;
                pos = best;
            end
        endfunction

        function void note_command(bmhq_pkg::cmd_t op, logic signed [bmhq_pkg::VALUE_W-1:0] v);
            heap_result_t r;
            r.st = bmhq_pkg::ST_OK;
            if (op == bmhq_pkg::CMD_INSERT) begin
                if (held >= DEPTH)
                    r.st = bmhq_pkg::ST_FULL;
                else
                    push_value(v);
            end
            else begin
                if (held == 0)
                    r.st = bmhq_pkg::ST_EMPTY;
                else
                    pop_min();
            end
            r.top   = (held != 0) ? heap_slots[0] : '0;
            r.cnt   = held[bmhq_pkg::COUNT_W-1:0];
            r.empty = (held == 0);
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [bmhq_pkg::STATUS_W-1:0] st,
                                   logic signed [bmhq_pkg::VALUE_W-1:0] top,
                                   logic [bmhq_pkg::COUNT_W-1:0] cnt, logic empty);
            heap_result_t r;
            if (pending_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: status=%0d top=%0d count=%0d empty=%0b",
                             st, top, cnt, empty);
                return;
            end
            r = pending_results.pop_front();
            if (st !== r.st || top !== r.top || cnt !== r.cnt || empty !== r.empty) begin
                faults++;
                if (faults <= 10)
                    $display({"mismatch: expected status=%0d top=%0d count=%0d empty=%0b,",
                              " got status=%0d top=%0d count=%0d empty=%0b"},
                             r.st, r.top, r.cnt, r.empty, st, top, cnt, empty);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                command = 1'b0;
    logic signed [bmhq_pkg::VALUE_W-1:0] value = '0;
    logic                                busy;
    logic                                done;
    logic [bmhq_pkg::STATUS_W-1:0]       status;
    logic signed [bmhq_pkg::VALUE_W-1:0] top_value;
    logic [bmhq_pkg::COUNT_W-1:0]        count;
    logic                                is_empty;

    min_heap_tracker sb = new();
    int              quiet_cycles = 0;
    int              level_est = 0;

    binary_min_heap_queue_top #(.HEAP_DEPTH(DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .done      (done),
        .status    (status),
        .top_value (top_value),
        .count     (count),
        .is_empty  (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Check results, note accepted commands, and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(status, top_value, count, is_empty);
            if (start && !busy)
                sb.note_command(bmhq_pkg::cmd_t'(command), value);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Hold start high until taken; returns then, or after a random idle gap with start low.
    task automatic send_command(input bmhq_pkg::cmd_t op,
                                input logic signed [bmhq_pkg::VALUE_W-1:0] v,
                                input int idle_pct);
        command <= op;
        value   <= v;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (op == bmhq_pkg::CMD_INSERT)
            level_est = (level_est < DEPTH) ? level_est + 1 : DEPTH;
        else
            level_est = (level_est > 0) ? level_est - 1 : 0;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic logic signed [bmhq_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return $urandom;
        else if (r < 9)
            return int'($urandom_range(8)) - 4;
        case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh8000_0001;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh7FFF_FFFE;
            4:       return -1;
            default: return 0;
        endcase
    endfunction

    task automatic random_command(input int insert_pct, input int idle_pct);
        if ($urandom_range(99) < insert_pct)
            send_command(bmhq_pkg::CMD_INSERT, pick_value(), idle_pct);
        else
            send_command(bmhq_pkg::CMD_REMOVE, $urandom, idle_pct);
    endtask

    initial
    begin
        int issued;
        int insert_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty removes, extremes, duplicates, then drain past empty.
        send_command(bmhq_pkg::CMD_REMOVE, 32'sh1234_5678, IDLE_PCT);
        send_command(bmhq_pkg::CMD_REMOVE, 0, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 0, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 32'sh8000_0000, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, -1, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 1, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 32'sh8000_0000, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 0, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 32'sh5555_5555, IDLE_PCT);
        send_command(bmhq_pkg::CMD_INSERT, 32'shAAAA_AAAA, IDLE_PCT);
        repeat (10) send_command(bmhq_pkg::CMD_REMOVE, $urandom, IDLE_PCT);

        // Fill to full with no idling at first, then push against the full heap.
        issued = 0;
        while (level_est < DEPTH) begin
            random_command(93, (issued < 250) ? 0 : IDLE_PCT);
            issued++;
        end
        repeat (6) begin
            send_command(bmhq_pkg::CMD_INSERT, pick_value(), IDLE_PCT);
            issued++;
        end
        repeat (4) begin
            send_command(bmhq_pkg::CMD_REMOVE, $urandom, IDLE_PCT);
            send_command(bmhq_pkg::CMD_INSERT, pick_value(), IDLE_PCT);
            send_command(bmhq_pkg::CMD_INSERT, pick_value(), IDLE_PCT);
            issued += 3;
        end

        // Drain past empty.
        while (level_est > 0) begin
            random_command(10, IDLE_PCT);
            issued++;
        end
        repeat (3) begin
            send_command(bmhq_pkg::CMD_REMOVE, $urandom, IDLE_PCT);
            issued++;
        end

        // Mixed traffic in short phases of varying insert bias.
        while (issued < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0:       insert_pct = 25;
                1:       insert_pct = 50;
                default: insert_pct = 75;
            endcase
            repeat (40) begin
                random_command(insert_pct, IDLE_PCT);
                issued++;
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.faults == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_cell.sv
rtl/binary_min_heap_queue_top.sv
tb/binary_min_heap_queue_top_tb.sv
